[hdl/ddpr_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ddpr_pkg
// Types and constants shared by the differential-drive pose rate pipeline.
// ----------------------------------------------------------------------------
package ddpr_pkg;

  localparam int DATA_W   = 16;
  localparam int CW       = 34;
  localparam int REM_W    = 33;
  localparam int DIV_BITS = 16;
  localparam logic signed [CW-1:0] CORDIC_GAIN = 34'sd652032874;

  localparam logic [0:0] REG_WHEEL_RADIUS = 1'b0;
  localparam logic [0:0] REG_AXLE_LENGTH  = 1'b1;

  typedef struct packed {
    logic signed [DATA_W-1:0] heading;
    logic signed [DATA_W-1:0] left_wheel_speed;
    logic signed [DATA_W-1:0] right_wheel_speed;
  } in_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] x_rate;
    logic signed [DATA_W-1:0] y_rate;
    logic signed [DATA_W-1:0] heading_rate;
    logic                     saturated;
  } out_t;

  typedef struct packed {
    logic signed [CW-1:0]     x;
    logic signed [CW-1:0]     y;
    logic signed [CW-1:0]     z;
    logic                     flip;
    logic signed [DATA_W:0]   sum;
    logic [REM_W-1:0]         rem;
    logic [DIV_BITS-1:0]      quo;
    logic                     neg;
    logic                     nz;
    logic                     big;
  } stage_t;

  function automatic logic [31:0] atan_turn(input logic [4:0] idx);
    logic [31:0] v;
    unique case (idx)
      5'd0:  v = 32'h20000000;
      5'd1:  v = 32'h12E4051E;
      5'd2:  v = 32'h09FB385B;
      5'd3:  v = 32'h051111D4;
      5'd4:  v = 32'h028B0D43;
      5'd5:  v = 32'h0145D7E1;
      5'd6:  v = 32'h00A2F61E;
      5'd7:  v = 32'h00517C55;
      5'd8:  v = 32'h0028BE53;
      5'd9:  v = 32'h00145F2F;
      5'd10: v = 32'h000A2F98;
      5'd11: v = 32'h000517CC;
      5'd12: v = 32'h00028BE6;
      5'd13: v = 32'h000145F3;
      5'd14: v = 32'h0000A2F9;
      5'd15: v = 32'h0000517C;
      5'd16: v = 32'h000028BE;
      5'd17: v = 32'h0000145F;
      5'd18: v = 32'h00000A2F;
      5'd19: v = 32'h00000517;
      5'd20: v = 32'h0000028B;
      5'd21: v = 32'h00000145;
      5'd22: v = 32'h000000A2;
      5'd23: v = 32'h00000051;
      default: v = 32'h0;
    endcase
    return v;
  endfunction

endpackage

[hdl/diff_drive_pose_rate.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// diff_drive_pose_rate
// Pose rate of a differential-drive base from heading and wheel speeds.
// ----------------------------------------------------------------------------
// in_valid/in_ready carry heading and wheel speeds, out_valid/out_ready carry
// x, y and heading rates plus a saturation flag; one result per transaction.
// wheel_radius (addr 0) and axle_length (addr 4) sit on the apb port; the user
// must write them only while the pipeline is empty, the block does not enforce it.
// from accept to out_valid a transaction passes two entry stages, one stage
// per CORDIC rotation / quotient bit, three multiply and rounding stages and
// the output register.
// throughput is one transaction per cycle while the output is not stalled.
// while out_valid is high and out_ready low the whole pipeline holds and
// in_ready drops; nothing is lost or repeated.
// reset clears all valid bits and loads radius 410, length 2048.
// ----------------------------------------------------------------------------
module diff_drive_pose_rate #(
  parameter int CORDIC_STAGES = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  ddpr_pkg::in_t     in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output ddpr_pkg::out_t    out_data,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  localparam int MST = (CORDIC_STAGES > ddpr_pkg::DIV_BITS) ? CORDIC_STAGES
                                                            : ddpr_pkg::DIV_BITS;
  localparam int NV  = MST + 5;

  logic [15:0] radius_r;
  logic [15:0] length_r;
  logic        en;
  logic [NV-1:0] vld_r;
  logic        out_valid_r;

  // configuration
  assign pready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r <= 16'd410;
      length_r <= 16'd2048;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[2])
        ddpr_pkg::REG_WHEEL_RADIUS: radius_r <= pwdata[15:0];
        ddpr_pkg::REG_AXLE_LENGTH:  length_r <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      ddpr_pkg::REG_WHEEL_RADIUS: prdata = {16'h0, radius_r};
      ddpr_pkg::REG_AXLE_LENGTH:  prdata = {16'h0, length_r};
      default: prdata = 32'h0;
    endcase
  end

  assign en       = !out_valid_r || out_ready;
  assign in_ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      vld_r       <= {vld_r[NV-2:0], in_valid};
      out_valid_r <= vld_r[NV-1];
    end
  end

  // entry stage 0: angle fold, wheel sum and difference product
  ddpr_pkg::stage_t pre0_r, pre0_nxt;
  logic signed [33:0] num_r, num_nxt;
  logic               flip;
  logic [15:0]        hfold;
  logic signed [31:0] zt;
  logic signed [16:0] diff;

  always_comb begin
    flip  = in_data.heading[15] ^ in_data.heading[14];
    hfold = flip ? in_data.heading + 16'h8000 : in_data.heading;
    zt    = $signed({hfold, 16'h0000});
    diff  = $signed({in_data.right_wheel_speed[15], in_data.right_wheel_speed})
          - $signed({in_data.left_wheel_speed[15], in_data.left_wheel_speed});
    pre0_nxt      = '0;
    pre0_nxt.x    = ddpr_pkg::CORDIC_GAIN;
    pre0_nxt.z    = {{2{zt[31]}}, zt};
    pre0_nxt.flip = flip;
    pre0_nxt.sum  = $signed({in_data.left_wheel_speed[15], in_data.left_wheel_speed})
                  + $signed({in_data.right_wheel_speed[15], in_data.right_wheel_speed});
    num_nxt       = $signed({1'b0, radius_r}) * diff;
  end

  // entry stage 1: magnitude plus half divisor
  ddpr_pkg::stage_t pre1_r, pre1_nxt;
  logic [33:0] mag;

  always_comb begin
    mag          = num_r[33] ? 34'(-num_r) : 34'(num_r);
    pre1_nxt     = pre0_r;
    pre1_nxt.neg = num_r[33];
    pre1_nxt.nz  = (num_r != '0);
    pre1_nxt.rem = mag[32:0] + ddpr_pkg::REM_W'(length_r[15:1]);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pre0_r <= pre0_nxt;
      num_r  <= num_nxt;
      pre1_r <= pre1_nxt;
    end
  end

  // rotation and divide chain
  ddpr_pkg::stage_t chain [0:MST];

  always_comb begin
    chain[0]     = pre1_r;
    chain[0].big = pre1_r.nz && ((length_r == 16'h0) ||
                   (pre1_r.rem >= {1'b0, length_r, 16'h0000}));
  end

  for (genvar k = 0; k < MST; k++) begin : g_stage
    ddpr_stage #(
      .IDX           (k),
      .CORDIC_STAGES (CORDIC_STAGES)
    ) u_stage (
      .clk         (clk),
      .en          (en),
      .axle_length (length_r),
      .d           (chain[k]),
      .q_r         (chain[k+1])
    );
  end

  // post stage 0: trig rounding and heading rate clip
  ddpr_pkg::stage_t            last;
  logic signed [33:0]          xf, yf, xs, ys;
  logic signed [16:0]          c_r, s_r, c_nxt, s_nxt;
  logic signed [15:0]          hr_r, hr_nxt;
  logic                        hs_r, hs_nxt;
  logic signed [16:0]          sum0_r, sum1_r;
  logic signed [15:0]          hr1_r, hr2_r;
  logic                        hs1_r, hs2_r;

  always_comb begin
    last  = chain[MST];
    xf    = last.flip ? -last.x : last.x;
    yf    = last.flip ? -last.y : last.y;
    xs    = (xf + 34'sd16384) >>> 15;
    ys    = (yf + 34'sd16384) >>> 15;
    c_nxt = xs[16:0];
    s_nxt = ys[16:0];
    hs_nxt = 1'b0;
    priority if (!last.nz) begin
      hr_nxt = '0;
    end else if (last.big) begin
      hr_nxt = last.neg ? 16'sh8000 : 16'sh7fff;
      hs_nxt = 1'b1;
    end else if (last.neg) begin
      if (last.quo > 16'd32768) begin
        hr_nxt = 16'sh8000;
        hs_nxt = 1'b1;
      end else begin
        hr_nxt = 16'(-last.quo);
      end
    end else begin
      if (last.quo > 16'd32767) begin
        hr_nxt = 16'sh7fff;
        hs_nxt = 1'b1;
      end else begin
        hr_nxt = $signed(last.quo);
      end
    end
  end

  // post stages 1 and 2: radius and wheel sum products
  logic signed [33:0] pc_r, ps_r;
  logic signed [50:0] xp_r, yp_r;

  always_ff @(posedge clk) begin
    if (en) begin
      c_r    <= c_nxt;
      s_r    <= s_nxt;
      hr_r   <= hr_nxt;
      hs_r   <= hs_nxt;
      sum0_r <= last.sum;
      pc_r   <= $signed({1'b0, radius_r}) * c_r;
      ps_r   <= $signed({1'b0, radius_r}) * s_r;
      hr1_r  <= hr_r;
      hs1_r  <= hs_r;
      sum1_r <= sum0_r;
      xp_r   <= pc_r * sum1_r;
      yp_r   <= ps_r * sum1_r;
      hr2_r  <= hr1_r;
      hs2_r  <= hs1_r;
    end
  end

  // output register: round, shift, clip
  ddpr_pkg::out_t     out_r, out_nxt;
  logic signed [50:0] xt, yt;
  logic               xsat, ysat;

  always_comb begin
    xt   = (xp_r + 51'sd134217728) >>> 28;
    yt   = (yp_r + 51'sd134217728) >>> 28;
    xsat = 1'b0;
    ysat = 1'b0;
    out_nxt = '0;
    if (xt > 51'sd32767) begin
      out_nxt.x_rate = 16'sh7fff;
      xsat = 1'b1;
    end else if (xt < -51'sd32768) begin
      out_nxt.x_rate = 16'sh8000;
      xsat = 1'b1;
    end else begin
      out_nxt.x_rate = xt[15:0];
    end
    if (yt > 51'sd32767) begin
      out_nxt.y_rate = 16'sh7fff;
      ysat = 1'b1;
    end else if (yt < -51'sd32768) begin
      out_nxt.y_rate = 16'sh8000;
      ysat = 1'b1;
    end else begin
      out_nxt.y_rate = yt[15:0];
    end
    out_nxt.heading_rate = hr2_r;
    out_nxt.saturated    = xsat | ysat | hs2_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

[hdl/ddpr_stage.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ddpr_stage
// One pipeline stage: a CORDIC rotation step and/or a restoring divide step.
// ----------------------------------------------------------------------------
module ddpr_stage #(
  parameter int IDX           = 0,
  parameter int CORDIC_STAGES = 16
) (
  input  logic             clk,
  input  logic             en,
  input  logic [15:0]      axle_length,
  input  ddpr_pkg::stage_t d,
  output ddpr_pkg::stage_t q_r
);

  ddpr_pkg::stage_t q_nxt;
  logic signed [ddpr_pkg::CW-1:0] dx;
  logic signed [ddpr_pkg::CW-1:0] dy;
  logic signed [ddpr_pkg::CW-1:0] da;
  logic [ddpr_pkg::REM_W-1:0]     dv;

  always_comb begin
    q_nxt = d;
    dx = d.y >>> IDX;
    dy = d.x >>> IDX;
    da = $signed({2'b00, ddpr_pkg::atan_turn(5'(IDX))});
    dv = ddpr_pkg::REM_W'(axle_length) << (ddpr_pkg::DIV_BITS - 1 - IDX);
    if (IDX < CORDIC_STAGES) begin
      if (!d.z[ddpr_pkg::CW-1]) begin
        q_nxt.x = d.x - dx;
        q_nxt.y = d.y + dy;
        q_nxt.z = d.z - da;
      end else begin
        q_nxt.x = d.x + dx;
        q_nxt.y = d.y - dy;
        q_nxt.z = d.z + da;
      end
    end
    if (IDX < ddpr_pkg::DIV_BITS) begin
      if (d.rem >= dv) begin
        q_nxt.rem = d.rem - dv;
        q_nxt.quo = d.quo | (ddpr_pkg::DIV_BITS'(1) << (ddpr_pkg::DIV_BITS - 1 - IDX));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q_r <= q_nxt;
    end
  end

endmodule

[hdl/ddpr_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ddpr_checker
// Port-level checks for diff_drive_pose_rate, bound to the top level.
// ----------------------------------------------------------------------------
module ddpr_checker (
  input logic           clk,
  input logic           rst_n,
  input logic           in_ready,
  input logic           out_valid,
  input logic           out_ready,
  input ddpr_pkg::out_t out_data
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  a_stall: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |-> !in_ready)
    else $error("input taken while pipeline stalled");

  a_sat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.saturated |->
      out_data.x_rate == 16'sh7fff || out_data.x_rate == 16'sh8000 ||
      out_data.y_rate == 16'sh7fff || out_data.y_rate == 16'sh8000 ||
      out_data.heading_rate == 16'sh7fff || out_data.heading_rate == 16'sh8000)
    else $error("saturation flag without a clipped rate");

  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind diff_drive_pose_rate ddpr_checker u_ddpr_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
